// ===== src/ttm_pkg.sv =====
package ttm_pkg;

    typedef struct packed {
        logic [3:0] from_state;
        logic [7:0] read_symbol;
        logic [3:0] next_state;
        logic [7:0] write_symbol;
        logic [1:0] move;
    } rule_t;

    typedef struct packed {
        logic       load;
        logic [4:0] slot;
        rule_t      rule;
    } rule_load_t;

    localparam logic [2:0] CMD_LOAD_RULE = 3'd0;
    localparam logic [2:0] CMD_LOAD_CELL = 3'd1;
    localparam logic [2:0] CMD_RESTART   = 3'd2;
    localparam logic [2:0] CMD_STEP      = 3'd3;
    localparam logic [2:0] CMD_READ_CELL = 3'd4;

    localparam logic [2:0] ST_DONE        = 3'd0;
    localparam logic [2:0] ST_STEPPED     = 3'd1;
    localparam logic [2:0] ST_HALTED      = 3'd2;
    localparam logic [2:0] ST_NO_RULE     = 3'd3;
    localparam logic [2:0] ST_OFF_TAPE    = 3'd4;
    localparam logic [2:0] ST_NOT_RUNNING = 3'd5;

    localparam logic [1:0] MOVE_LEFT  = 2'd1;
    localparam logic [1:0] MOVE_RIGHT = 2'd2;

    localparam logic [1:0] REG_RULE_COUNT  = 2'd0;
    localparam logic [1:0] REG_TAPE_LENGTH = 2'd1;
    localparam logic [1:0] REG_START_STATE = 2'd2;

    localparam logic [3:0] HALT_STATE = 4'd0;

endpackage

// ===== src/ttm_rule_cell.sv =====
module ttm_rule_cell #(
    parameter int INDEX = 0
) (
    input  logic               clk,
    input  ttm_pkg::rule_load_t load_bus,
    input  logic [5:0]         rule_count,
    input  logic [3:0]         cur_state,
    input  logic [7:0]         cur_symbol,
    input  logic               hit_in,
    output logic               hit_out,
    output logic               win,
    output ttm_pkg::rule_t     rule
);

    localparam int CMP_W = 9;

    ttm_pkg::rule_t rule_reg;
    logic           enabled;
    logic           match;

    always_ff @(posedge clk)
    begin
        if (load_bus.load && ({4'b0, load_bus.slot} == CMP_W'(INDEX)))
        begin
            rule_reg <= load_bus.rule;
        end
    end

    assign enabled = CMP_W'(INDEX) < {3'b0, rule_count};
    assign match   = enabled && (rule_reg.from_state == cur_state)
                     && (rule_reg.read_symbol == cur_symbol);
    assign hit_out = hit_in | match;
    assign win     = match & ~hit_in;
    assign rule    = rule_reg;

endmodule

// ===== src/ttm_tape.sv =====
module ttm_tape #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/turing_machine_step_engine.sv =====
// Channel    Direction  Handshake              Beat
// config     in         psel/penable/pready    one register write or read
// command    in         cmd_valid/cmd_ready    one command with its rule and cell fields
// response   out        rsp_valid/rsp_ready    one status beat per command
//
// Each command is handled in order: the accept cycle reads the tape memory and the execute
// state runs the rule match through the cell chain and writes the tape back.
// A new command is accepted in the cycle after the execute state, so none is taken before the last is through.
// The execute state waits while an earlier response beat has not been taken.
// Reset clears the machine state and sets the configuration to its defaults; rules and tape hold nothing until loaded.
module turing_machine_step_engine #(
    parameter int RULES      = 32,
    parameter int TAPE_CELLS = 256
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  logic [2:0]  command,
    input  logic [4:0]  rule_slot,
    input  logic [3:0]  rule_from_state,
    input  logic [7:0]  rule_read_symbol,
    input  logic [3:0]  rule_next_state,
    input  logic [7:0]  rule_write_symbol,
    input  logic [1:0]  rule_move,
    input  logic [7:0]  cell_position,
    input  logic [7:0]  cell_symbol,

    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [2:0]  status,
    output logic [3:0]  machine_state,
    output logic [7:0]  head_position,
    output logic [7:0]  symbol_out,
    output logic [4:0]  matched_rule
);

    localparam int RIDX_W = (RULES > 1) ? $clog2(RULES) : 1;
    localparam int TIDX_W = $clog2(TAPE_CELLS);
    localparam int CW     = TIDX_W + 9;

    typedef enum logic {S_IDLE, S_EXEC} fsm_t;

    fsm_t        fsm_reg, fsm_next;
    logic [5:0]  rule_count_reg, rule_count_next;
    logic [8:0]  tape_length_reg, tape_length_next;
    logic [3:0]  start_state_reg, start_state_next;
    logic [3:0]  state_reg, state_next;
    logic [TIDX_W-1:0] head_reg, head_next;
    logic        running_reg, running_next;
    logic        rsp_valid_reg, rsp_valid_next;
    logic [2:0]  rsp_status_reg, rsp_status_next;
    logic [7:0]  rsp_symbol_reg, rsp_symbol_next;
    logic [4:0]  rsp_matched_reg, rsp_matched_next;

    logic [2:0]     item_cmd_reg;
    logic [4:0]     item_slot_reg;
    ttm_pkg::rule_t item_rule_reg;
    logic [7:0]     item_pos_reg;
    logic [7:0]     item_sym_reg;

    logic cfg_we;
    logic accept;
    logic finish;

    logic [CW-1:0] tl_ext;
    logic [CW-1:0] len;
    logic [CW-1:0] head_ext;
    logic          head_off;
    logic          off_edge;

    logic [TIDX_W+7:0] in_pos_wide;
    logic [TIDX_W+7:0] item_pos_wide;
    logic              in_pos_ok;
    logic              item_pos_ok;

    logic [TIDX_W-1:0] tape_rd_addr;
    logic [7:0]        tape_rd_data;
    logic              tape_we;
    logic [TIDX_W-1:0] tape_wa;
    logic [7:0]        tape_wd;

    ttm_pkg::rule_load_t load_bus;
    logic [RULES:0]      hit;
    logic [RULES-1:0]    win;
    ttm_pkg::rule_t      cell_rule [RULES];
    ttm_pkg::rule_t      sel_rule;
    logic [RIDX_W-1:0]   sel_idx;
    logic [RIDX_W+4:0]   sel_idx_wide;
    logic [TIDX_W+7:0]   head_wide;

    assign pready    = 1'b1;
    assign cfg_we    = psel && penable && pwrite && pready;
    assign cmd_ready = (fsm_reg == S_IDLE);
    assign accept    = cmd_valid && cmd_ready;
    assign finish    = (fsm_reg == S_EXEC) && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        unique case (paddr[3:2])
            ttm_pkg::REG_RULE_COUNT:  prdata = {26'b0, rule_count_reg};
            ttm_pkg::REG_TAPE_LENGTH: prdata = {23'b0, tape_length_reg};
            ttm_pkg::REG_START_STATE: prdata = {28'b0, start_state_reg};
            default:                  prdata = '0;
        endcase
    end

    assign tl_ext   = CW'(tape_length_reg);
    assign len      = (tl_ext < CW'(TAPE_CELLS)) ? tl_ext : CW'(TAPE_CELLS);
    assign head_ext = CW'(head_reg);
    assign head_off = head_ext >= len;

    assign in_pos_wide   = {{TIDX_W{1'b0}}, cell_position};
    assign item_pos_wide = {{TIDX_W{1'b0}}, item_pos_reg};
    assign in_pos_ok     = CW'(cell_position) < CW'(TAPE_CELLS);
    assign item_pos_ok   = CW'(item_pos_reg) < CW'(TAPE_CELLS);

    assign tape_rd_addr = (command == ttm_pkg::CMD_READ_CELL)
                          ? (in_pos_ok ? in_pos_wide[TIDX_W-1:0] : '0)
                          : head_reg;

    ttm_tape #(
        .DEPTH (TAPE_CELLS),
        .AW    (TIDX_W)
    ) u_tape (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (tape_rd_addr),
        .rd_data (tape_rd_data),
        .wr_en   (tape_we),
        .wr_addr (tape_wa),
        .wr_data (tape_wd)
    );

    assign load_bus.load = finish && (item_cmd_reg == ttm_pkg::CMD_LOAD_RULE);
    assign load_bus.slot = item_slot_reg;
    assign load_bus.rule = item_rule_reg;
    assign hit[0]        = 1'b0;

    for (genvar i = 0; i < RULES; i++)
    begin : g_cell
        ttm_rule_cell #(
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .load_bus   (load_bus),
            .rule_count (rule_count_reg),
            .cur_state  (state_reg),
            .cur_symbol (tape_rd_data),
            .hit_in     (hit[i]),
            .hit_out    (hit[i+1]),
            .win        (win[i]),
            .rule       (cell_rule[i])
        );
    end

    always_comb
    begin
        sel_rule = '0;
        sel_idx  = '0;
        for (int i = 0; i < RULES; i++)
        begin
            if (win[i])
            begin
                sel_rule = sel_rule | cell_rule[i];
                sel_idx  = sel_idx | RIDX_W'(i);
            end
        end
    end

    assign sel_idx_wide = {5'b0, sel_idx};

    always_comb
    begin
        fsm_next         = fsm_reg;
        rule_count_next  = rule_count_reg;
        tape_length_next = tape_length_reg;
        start_state_next = start_state_reg;
        state_next       = state_reg;
        head_next        = head_reg;
        running_next     = running_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        rsp_status_next  = rsp_status_reg;
        rsp_symbol_next  = rsp_symbol_reg;
        rsp_matched_next = rsp_matched_reg;
        tape_we          = 1'b0;
        tape_wa          = item_pos_wide[TIDX_W-1:0];
        tape_wd          = item_sym_reg;
        off_edge         = 1'b0;

        if (cfg_we)
        begin
            unique case (paddr[3:2])
                ttm_pkg::REG_RULE_COUNT:  rule_count_next  = pwdata[5:0];
                ttm_pkg::REG_TAPE_LENGTH: tape_length_next = pwdata[8:0];
                ttm_pkg::REG_START_STATE: start_state_next = pwdata[3:0];
                default:                  ;
            endcase
        end

        if (accept)
        begin
            fsm_next = S_EXEC;
        end

        if (finish)
        begin
            fsm_next         = S_IDLE;
            rsp_valid_next   = 1'b1;
            rsp_status_next  = ttm_pkg::ST_DONE;
            rsp_symbol_next  = '0;
            rsp_matched_next = '0;
            unique case (item_cmd_reg)
                ttm_pkg::CMD_LOAD_CELL:
                begin
                    tape_we = item_pos_ok;
                end
                ttm_pkg::CMD_RESTART:
                begin
                    state_next   = start_state_reg;
                    head_next    = '0;
                    running_next = (start_state_reg != ttm_pkg::HALT_STATE);
                end
                ttm_pkg::CMD_READ_CELL:
                begin
                    rsp_symbol_next = item_pos_ok ? tape_rd_data : '0;
                end
                ttm_pkg::CMD_STEP:
                begin
                    priority if (!running_reg)
                    begin
                        rsp_status_next = ttm_pkg::ST_NOT_RUNNING;
                    end
                    else if (head_off)
                    begin
                        rsp_status_next = ttm_pkg::ST_OFF_TAPE;
                        running_next    = 1'b0;
                    end
                    else if (!hit[RULES])
                    begin
                        rsp_status_next = ttm_pkg::ST_NO_RULE;
                        rsp_symbol_next = tape_rd_data;
                        running_next    = 1'b0;
                    end
                    else
                    begin
                        tape_we = 1'b1;
                        tape_wa = head_reg;
                        tape_wd = sel_rule.write_symbol;
                        if (sel_rule.move == ttm_pkg::MOVE_LEFT)
                        begin
                            if (head_reg == '0)
                            begin
                                off_edge = 1'b1;
                            end
                            else
                            begin
                                head_next = head_reg - 1'b1;
                            end
                        end
                        else if (sel_rule.move == ttm_pkg::MOVE_RIGHT)
                        begin
                            if ((head_ext + 1'b1) >= len)
                            begin
                                off_edge = 1'b1;
                            end
                            else
                            begin
                                head_next = head_reg + 1'b1;
                            end
                        end
                        state_next       = sel_rule.next_state;
                        rsp_symbol_next  = sel_rule.write_symbol;
                        rsp_matched_next = sel_idx_wide[4:0];
                        priority if (sel_rule.next_state == ttm_pkg::HALT_STATE)
                        begin
                            rsp_status_next = ttm_pkg::ST_HALTED;
                            running_next    = 1'b0;
                        end
                        else if (off_edge)
                        begin
                            rsp_status_next = ttm_pkg::ST_OFF_TAPE;
                            running_next    = 1'b0;
                        end
                        else
                        begin
                            rsp_status_next = ttm_pkg::ST_STEPPED;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg         <= S_IDLE;
            rule_count_reg  <= 6'd0;
            tape_length_reg <= 9'd256;
            start_state_reg <= 4'd1;
            state_reg       <= '0;
            head_reg        <= '0;
            running_reg     <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            rsp_status_reg  <= '0;
            rsp_symbol_reg  <= '0;
            rsp_matched_reg <= '0;
        end
        else
        begin
            fsm_reg         <= fsm_next;
            rule_count_reg  <= rule_count_next;
            tape_length_reg <= tape_length_next;
            start_state_reg <= start_state_next;
            state_reg       <= state_next;
            head_reg        <= head_next;
            running_reg     <= running_next;
            rsp_valid_reg   <= rsp_valid_next;
            rsp_status_reg  <= rsp_status_next;
            rsp_symbol_reg  <= rsp_symbol_next;
            rsp_matched_reg <= rsp_matched_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_cmd_reg                <= command;
            item_slot_reg               <= rule_slot;
            item_rule_reg.from_state    <= rule_from_state;
            item_rule_reg.read_symbol   <= rule_read_symbol;
            item_rule_reg.next_state    <= rule_next_state;
            item_rule_reg.write_symbol  <= rule_write_symbol;
            item_rule_reg.move          <= rule_move;
            item_pos_reg                <= cell_position;
            item_sym_reg                <= cell_symbol;
        end
    end

    assign head_wide     = {8'b0, head_reg};
    assign rsp_valid     = rsp_valid_reg;
    assign status        = rsp_status_reg;
    assign machine_state = state_reg;
    assign head_position = head_wide[7:0];
    assign symbol_out    = rsp_symbol_reg;
    assign matched_rule  = rsp_matched_reg;

    // A response beat only appears out of the execute cycle.
    a_rsp_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(fsm_reg == S_EXEC))
        else $error("response raised without an execute cycle");

    // A running machine never sits in the halt state.
    a_running_not_halted: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> (state_reg != ttm_pkg::HALT_STATE))
        else $error("machine running in the halt state");

    // The head always rests on a cell of the tape.
    a_head_on_tape: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(head_reg) < CW'(TAPE_CELLS))
        else $error("head beyond the last tape cell");

    // During a live step the priority chain picks at most one rule.
    a_single_winner: assert property (@(posedge clk) disable iff (!rst_n)
        ((fsm_reg == S_EXEC) && (item_cmd_reg == ttm_pkg::CMD_STEP) && running_reg
         && !head_off) |-> $onehot0(win))
        else $error("more than one rule selected");

    // A stepped beat leaves the machine running while it waits.
    a_stepped_running: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_status_reg == ttm_pkg::ST_STEPPED)) |-> running_reg)
        else $error("stepped status with the machine stopped");

endmodule

// ===== tb/turing_machine_step_engine_tb.sv =====
`timescale 1ns / 1ps

module turing_machine_step_engine_tb;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 400;
    localparam int MAX_RULES    = 32;
    localparam int MAX_CELLS    = 256;
    localparam int SHOWN_ERRORS = 40;

    localparam logic [1:0] MOVE_STAY     = 2'd0;
    localparam logic [1:0] MOVE_UNUSED   = 2'd3;
    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [2:0] command;
        logic [4:0] rule_slot;
        logic [3:0] rule_from_state;
        logic [7:0] rule_read_symbol;
        logic [3:0] rule_next_state;
        logic [7:0] rule_write_symbol;
        logic [1:0] rule_move;
        logic [7:0] cell_position;
        logic [7:0] cell_symbol;
    } command_beat_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] machine_state;
        logic [7:0] head_position;
        logic [7:0] symbol_out;
        logic [4:0] matched_rule;
    } machine_result_t;

    typedef struct packed {
        command_beat_t   beat;
        machine_result_t result;
    } queued_command_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        cmd_valid = 1'b0;
    logic        cmd_ready;
    logic [2:0]  command = '0;
    logic [4:0]  rule_slot = '0;
    logic [3:0]  rule_from_state = '0;
    logic [7:0]  rule_read_symbol = '0;
    logic [3:0]  rule_next_state = '0;
    logic [7:0]  rule_write_symbol = '0;
    logic [1:0]  rule_move = '0;
    logic [7:0]  cell_position = '0;
    logic [7:0]  cell_symbol = '0;

    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    logic [2:0]  status;
    logic [3:0]  machine_state;
    logic [7:0]  head_position;
    logic [7:0]  symbol_out;
    logic [4:0]  matched_rule;

    turing_machine_step_engine dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .cmd_valid         (cmd_valid),
        .cmd_ready         (cmd_ready),
        .command           (command),
        .rule_slot         (rule_slot),
        .rule_from_state   (rule_from_state),
        .rule_read_symbol  (rule_read_symbol),
        .rule_next_state   (rule_next_state),
        .rule_write_symbol (rule_write_symbol),
        .rule_move         (rule_move),
        .cell_position     (cell_position),
        .cell_symbol       (cell_symbol),
        .rsp_valid         (rsp_valid),
        .rsp_ready         (rsp_ready),
        .status            (status),
        .machine_state     (machine_state),
        .head_position     (head_position),
        .symbol_out        (symbol_out),
        .matched_rule      (matched_rule)
    );

    ttm_pkg::rule_t rule_mem [MAX_RULES];
    logic [7:0]  tape_mem [MAX_CELLS];
    bit          slot_loaded [MAX_RULES];
    bit          cell_loaded [MAX_CELLS];
    logic [3:0]  m_state = ttm_pkg::HALT_STATE;
    int          m_head = 0;
    bit          m_running = 1'b0;
    logic [5:0]  cfg_rule_count = 6'd0;
    logic [8:0]  cfg_tape_length = 9'd256;
    logic [3:0]  cfg_start_state = 4'd1;

    queued_command_t command_backlog [$];
    machine_result_t machine_results_due [$];
    queued_command_t on_wire;

    int commands_queued = 0;
    int commands_accepted = 0;
    int results_seen = 0;
    int random_items = 0;
    int mismatches = 0;
    int cycle_count = 0;
    int send_gap = 0;
    int recv_stall = 0;
    bit beat_taken = 1'b0;
    bit no_idle = 1'b0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string text);
        if (mismatches < SHOWN_ERRORS)
        begin
            $display("MISMATCH: %s", text);
        end
        mismatches++;
    endtask

    function automatic int rule_span();
        return (cfg_rule_count < MAX_RULES) ? int'(cfg_rule_count) : MAX_RULES;
    endfunction

    function automatic int tape_span();
        return (cfg_tape_length < MAX_CELLS) ? int'(cfg_tape_length) : MAX_CELLS;
    endfunction

    function automatic machine_result_t advance_machine(input command_beat_t b);
        machine_result_t r;
        ttm_pkg::rule_t  fired;
        logic [7:0]      sym;
        int              span;
        int              hit;
        bit              off;
        r = '0;
        span = tape_span();
        case (b.command)
            ttm_pkg::CMD_LOAD_RULE:
            begin
                rule_mem[b.rule_slot] = '{from_state: b.rule_from_state,
                                          read_symbol: b.rule_read_symbol,
                                          next_state: b.rule_next_state,
                                          write_symbol: b.rule_write_symbol,
                                          move: b.rule_move};
            end
            ttm_pkg::CMD_LOAD_CELL:
            begin
                tape_mem[b.cell_position] = b.cell_symbol;
            end
            ttm_pkg::CMD_RESTART:
            begin
                m_state = cfg_start_state;
                m_head = 0;
                m_running = (cfg_start_state != ttm_pkg::HALT_STATE);
            end
            ttm_pkg::CMD_STEP:
            begin
                if (!m_running)
                begin
                    r.status = ttm_pkg::ST_NOT_RUNNING;
                end
                else if (m_head >= span)
                begin
                    r.status = ttm_pkg::ST_OFF_TAPE;
                    m_running = 1'b0;
                end
                else
                begin
                    sym = tape_mem[m_head];
                    hit = -1;
                    for (int i = 0; i < rule_span(); i++)
                    begin
                        if (hit < 0 && rule_mem[i].from_state == m_state
                            && rule_mem[i].read_symbol == sym)
                        begin
                            hit = i;
                        end
                    end
                    if (hit < 0)
                    begin
                        r.status = ttm_pkg::ST_NO_RULE;
                        r.symbol_out = sym;
                        m_running = 1'b0;
                    end
                    else
                    begin
                        fired = rule_mem[hit];
                        off = 1'b0;
                        tape_mem[m_head] = fired.write_symbol;
                        if (fired.move == ttm_pkg::MOVE_LEFT)
                        begin
                            if (m_head == 0) off = 1'b1;
                            else m_head--;
                        end
                        else if (fired.move == ttm_pkg::MOVE_RIGHT)
                        begin
                            if (m_head + 1 >= span) off = 1'b1;
                            else m_head++;
                        end
                        m_state = fired.next_state;
                        r.matched_rule = 5'(hit);
                        r.symbol_out = fired.write_symbol;
                        if (fired.next_state == ttm_pkg::HALT_STATE)
                        begin
                            r.status = ttm_pkg::ST_HALTED;
                            m_running = 1'b0;
                        end
                        else if (off)
                        begin
                            r.status = ttm_pkg::ST_OFF_TAPE;
                            m_running = 1'b0;
                        end
                        else
                        begin
                            r.status = ttm_pkg::ST_STEPPED;
                        end
                    end
                end
            end
            ttm_pkg::CMD_READ_CELL:
            begin
                r.symbol_out = tape_mem[b.cell_position];
            end
            default: ;
        endcase
        r.machine_state = m_state;
        r.head_position = 8'(m_head);
        return r;
    endfunction

    // Rules and cells are never read before they are written, so a step or a read that
    // would touch an empty entry is turned into the load that fills it.
    task automatic queue_command(input command_beat_t b);
        queued_command_t entry;
        int              empty_slot;
        empty_slot = -1;
        if (b.command == ttm_pkg::CMD_STEP && m_running && m_head < tape_span())
        begin
            for (int i = rule_span() - 1; i >= 0; i--)
            begin
                if (!slot_loaded[i]) empty_slot = i;
            end
            if (!cell_loaded[m_head])
            begin
                b.command = ttm_pkg::CMD_LOAD_CELL;
                b.cell_position = 8'(m_head);
            end
            else if (empty_slot >= 0)
            begin
                b.command = ttm_pkg::CMD_LOAD_RULE;
                b.rule_slot = 5'(empty_slot);
            end
        end
        if (b.command == ttm_pkg::CMD_READ_CELL && !cell_loaded[b.cell_position])
        begin
            b.command = ttm_pkg::CMD_LOAD_CELL;
        end
        if (b.command == ttm_pkg::CMD_LOAD_RULE) slot_loaded[b.rule_slot] = 1'b1;
        if (b.command == ttm_pkg::CMD_LOAD_CELL) cell_loaded[b.cell_position] = 1'b1;
        entry.beat = b;
        entry.result = advance_machine(b);
        command_backlog.push_back(entry);
        commands_queued++;
    endtask

    function automatic command_beat_t noise_beat(input logic [2:0] op);
        command_beat_t b;
        logic [63:0]   raw;
        raw = {$urandom, $urandom};
        b = raw[$bits(command_beat_t)-1:0];
        b.command = op;
        return b;
    endfunction

    function automatic logic [7:0] tape_symbol();
        if ($urandom_range(0, 9) == 0) return 8'($urandom);
        return 8'($urandom_range(0, 3));
    endfunction

    function automatic logic [3:0] rule_state();
        case ($urandom_range(0, 9))
            0: return cfg_start_state;
            1: return 4'($urandom);
            default: return 4'($urandom_range(1, 4));
        endcase
    endfunction

    function automatic command_beat_t rule_fields(input command_beat_t b);
        b.command = ttm_pkg::CMD_LOAD_RULE;
        b.rule_from_state = rule_state();
        b.rule_read_symbol = tape_symbol();
        b.rule_next_state = ($urandom_range(0, 9) == 0) ? ttm_pkg::HALT_STATE : rule_state();
        b.rule_write_symbol = tape_symbol();
        b.rule_move = 2'($urandom);
        return b;
    endfunction

    function automatic command_beat_t random_beat();
        command_beat_t b;
        int            pick;
        b = noise_beat(ttm_pkg::CMD_STEP);
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            if (!m_running && $urandom_range(0, 3) != 0) b.command = ttm_pkg::CMD_RESTART;
        end
        else if (pick < 78)
        begin
            b.command = ttm_pkg::CMD_READ_CELL;
            if ($urandom_range(0, 3) != 0) b.cell_position = 8'($urandom_range(0, 15));
        end
        else if (pick < 86)
        begin
            b.command = ttm_pkg::CMD_LOAD_CELL;
            b.cell_position = 8'($urandom_range(0, 23));
            b.cell_symbol = tape_symbol();
        end
        else if (pick < 91)
        begin
            b = rule_fields(b);
        end
        else if (pick < 95)
        begin
            b.command = ttm_pkg::CMD_RESTART;
        end
        else
        begin
            b.command = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        end
        return b;
    endfunction

    task automatic load_rule(input int slot, input int src, input int sym_in, input int dst,
                             input int sym_wr, input logic [1:0] mv);
        command_beat_t b;
        b = noise_beat(ttm_pkg::CMD_LOAD_RULE);
        b.rule_slot = 5'(slot);
        b.rule_from_state = 4'(src);
        b.rule_read_symbol = 8'(sym_in);
        b.rule_next_state = 4'(dst);
        b.rule_write_symbol = 8'(sym_wr);
        b.rule_move = mv;
        queue_command(b);
    endtask

    task automatic load_cell(input int pos, input int sym);
        command_beat_t b;
        b = noise_beat(ttm_pkg::CMD_LOAD_CELL);
        b.cell_position = 8'(pos);
        b.cell_symbol = 8'(sym);
        queue_command(b);
    endtask

    task automatic read_cell(input int pos);
        command_beat_t b;
        b = noise_beat(ttm_pkg::CMD_READ_CELL);
        b.cell_position = 8'(pos);
        queue_command(b);
    endtask

    task automatic wait_for_drain();
        while (commands_accepted != commands_queued || machine_results_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [31:0] register_mask(input logic [1:0] index);
        case (index)
            ttm_pkg::REG_RULE_COUNT:  return 32'h3F;
            ttm_pkg::REG_TAPE_LENGTH: return 32'h1FF;
            default:                  return 32'hF;
        endcase
    endfunction

    task automatic check_register(input logic [1:0] index, input logic [31:0] want);
        logic [31:0] mask;
        mask = register_mask(index);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = {index, 2'b00};
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if ((prdata & mask) !== (want & mask))
        begin
            report_mismatch($sformatf("register %0d read %0d, expected %0d",
                                      index, prdata & mask, want & mask));
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic write_register(input logic [1:0] index, input int value);
        logic [31:0] mask;
        mask = register_mask(index);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {index, 2'b00};
        pwdata = ($urandom & ~mask) | (32'(value) & mask);
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (index)
            ttm_pkg::REG_RULE_COUNT:  cfg_rule_count = 6'(value);
            ttm_pkg::REG_TAPE_LENGTH: cfg_tape_length = 9'(value);
            default:                  cfg_start_state = 4'(value);
        endcase
        check_register(index, 32'(value));
    endtask

    task automatic set_machine_config(input int rules, input int cells, input int start);
        wait_for_drain();
        write_register(ttm_pkg::REG_RULE_COUNT, rules);
        write_register(ttm_pkg::REG_TAPE_LENGTH, cells);
        write_register(ttm_pkg::REG_START_STATE, start);
    endtask

    task automatic run_program(input int rules, input int cells, input int start,
                               input int ops);
        command_beat_t b;
        set_machine_config(rules, cells, start);
        for (int s = 0; s < rule_span(); s++)
        begin
            b = rule_fields(noise_beat(ttm_pkg::CMD_LOAD_RULE));
            b.rule_slot = 5'(s);
            queue_command(b);
        end
        for (int c = 0; c < tape_span() && c < 20; c++)
        begin
            load_cell(c, tape_symbol());
        end
        if ($urandom_range(0, 9) < 7) queue_command(noise_beat(ttm_pkg::CMD_RESTART));
        repeat (ops) queue_command(random_beat());
        random_items += ops;
    endtask

    always @(negedge clk)
    begin
        if (rst_n && (!cmd_valid || beat_taken))
        begin
            beat_taken = 1'b0;
            if (send_gap > 0)
            begin
                send_gap--;
                cmd_valid <= 1'b0;
            end
            else if (command_backlog.size() != 0)
            begin
                on_wire = command_backlog.pop_front();
                command           <= on_wire.beat.command;
                rule_slot         <= on_wire.beat.rule_slot;
                rule_from_state   <= on_wire.beat.rule_from_state;
                rule_read_symbol  <= on_wire.beat.rule_read_symbol;
                rule_next_state   <= on_wire.beat.rule_next_state;
                rule_write_symbol <= on_wire.beat.rule_write_symbol;
                rule_move         <= on_wire.beat.rule_move;
                cell_position     <= on_wire.beat.cell_position;
                cell_symbol       <= on_wire.beat.cell_symbol;
                cmd_valid         <= 1'b1;
                if (!no_idle && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 7);
            end
            else
            begin
                cmd_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (recv_stall > 0)
        begin
            recv_stall--;
            rsp_ready <= 1'b0;
        end
        else if (!no_idle && $urandom_range(0, 5) == 0)
        begin
            recv_stall = $urandom_range(0, 6);
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : beat_monitor
        machine_result_t want;
        if (rst_n)
        begin
            if (cmd_valid && cmd_ready)
            begin
                machine_results_due.push_back(on_wire.result);
                commands_accepted++;
                beat_taken = 1'b1;
            end
            if (rsp_valid && rsp_ready)
            begin
                if (machine_results_due.size() == 0)
                begin
                    report_mismatch($sformatf("response beat %0d with no command outstanding",
                                              results_seen));
                end
                else
                begin
                    want = machine_results_due.pop_front();
                    if (status !== want.status)
                        report_mismatch($sformatf("beat %0d status %0d, expected %0d",
                                                  results_seen, status, want.status));
                    if (machine_state !== want.machine_state)
                        report_mismatch($sformatf("beat %0d state %0d, expected %0d",
                                                  results_seen, machine_state,
                                                  want.machine_state));
                    if (head_position !== want.head_position)
                        report_mismatch($sformatf("beat %0d head %0d, expected %0d",
                                                  results_seen, head_position,
                                                  want.head_position));
                    if (symbol_out !== want.symbol_out)
                        report_mismatch($sformatf("beat %0d symbol %0d, expected %0d",
                                                  results_seen, symbol_out, want.symbol_out));
                    if (matched_rule !== want.matched_rule)
                        report_mismatch($sformatf("beat %0d rule %0d, expected %0d",
                                                  results_seen, matched_rule,
                                                  want.matched_rule));
                end
                results_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int phase;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        check_register(ttm_pkg::REG_RULE_COUNT, 0);
        check_register(ttm_pkg::REG_TAPE_LENGTH, 256);
        check_register(ttm_pkg::REG_START_STATE, 1);
        queue_command(noise_beat(ttm_pkg::CMD_STEP));

        set_machine_config(3, 3, 1);
        load_cell(0, 8'hFF);
        load_cell(1, 8'h00);
        load_cell(2, 8'h5A);
        load_cell(255, 8'hA5);
        read_cell(255);
        load_rule(0, 1, 8'hFF, 2, 8'h00, ttm_pkg::MOVE_RIGHT);
        load_rule(1, 2, 8'h00, 3, 8'hFF, MOVE_UNUSED);
        load_rule(2, 3, 8'hFF, 15, 8'h80, ttm_pkg::MOVE_LEFT);
        load_rule(31, 15, 8'h00, 7, 8'h3C, MOVE_STAY);
        queue_command(noise_beat(ttm_pkg::CMD_RESTART));
        repeat (5) queue_command(noise_beat(ttm_pkg::CMD_STEP));
        // A left move from the first cell runs off the tape.
        queue_command(noise_beat(ttm_pkg::CMD_RESTART));
        load_rule(2, 1, 8'h00, 4, 8'h11, ttm_pkg::MOVE_LEFT);
        queue_command(noise_beat(ttm_pkg::CMD_STEP));
        // Halting on the same move must report the halt rather than the edge.
        queue_command(noise_beat(ttm_pkg::CMD_RESTART));
        load_rule(2, 1, 8'h11, ttm_pkg::HALT_STATE, 8'h22, ttm_pkg::MOVE_LEFT);
        queue_command(noise_beat(ttm_pkg::CMD_STEP));
        queue_command(noise_beat(CMD_UNUSED_LO));
        queue_command(noise_beat(CMD_UNUSED_HI));
        read_cell(0);

        phase = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            case (phase)
                0: run_program(32, 256, 15, 60);
                1: run_program(0, 1, 1, 40);
                2: run_program(63, 511, 0, 30);
                3: run_program(6, 0, 2, 30);
                default:
                begin
                    run_program(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                            : $urandom_range(2, 16),
                                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511)
                                                            : $urandom_range(2, 24),
                                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                            : $urandom_range(1, 4),
                                $urandom_range(40, 80));
                end
            endcase
            phase++;
        end

        no_idle = 1'b1;
        run_program(8, 16, 1, 50);
        wait_for_drain();
        repeat (10) @(negedge clk);

        if (mismatches == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
